[design/rdls_pkg.sv]
// ----------------------------------------------------------------------------
// rdls_pkg
// Types and constants of the repeating delta-list send scheduler.
// ----------------------------------------------------------------------------
package rdls_pkg;

  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_W       = 5;
  localparam int unsigned BUF_IW      = 4;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_START  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_STOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_SHL  = 2'd1,
    CELL_INS  = 2'd2,
    CELL_SETD = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] delay;
    logic [15:0] period;
    logic [15:0] total;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   ent;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_POP  = 3'd1,
    ST_SEL  = 3'd2,
    ST_WALK = 3'd3,
    ST_INS  = 3'd4,
    ST_FIN  = 3'd5,
    ST_EMIT = 3'd6
  } state_e;

endpackage

[design/rdls_cell.sv]
// ----------------------------------------------------------------------------
// rdls_cell
// One list slot: holds an entry, shifts left, opens a gap or sets its delay.
// ----------------------------------------------------------------------------
module rdls_cell import rdls_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [CW-1:0] pos_i,
  input  entry_t        left_i,
  input  entry_t        right_i,
  output entry_t        ent_o
);

  entry_t ent_q, ent_d;
  logic   at_pos, past_pos;

  assign at_pos   = (pos_i == CW'(IDX));
  assign past_pos = (CW'(IDX) > pos_i);

  always_comb begin
    ent_d = ent_q;
    case (ctl_i.op)
      CELL_SHL: ent_d = right_i;
      CELL_INS: begin
        if (past_pos) ent_d = left_i;
        else if (at_pos) ent_d = ctl_i.ent;
      end
      CELL_SETD: begin
        if (at_pos) ent_d.delay = ctl_i.ent.delay;
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

[design/repeating_delta_list_send_scheduler.sv]
// ----------------------------------------------------------------------------
// repeating_delta_list_send_scheduler
// Delta-ordered send list kept in a row of cells, with pass sequencer.
// Append, stop and a tick that runs no pass keep busy low.
// A pass pops the due entries, selects each in turn, walks a repeating one
// to its slot and reinserts it, loads the countdown and emits one result per
// entry (one if none is sent and the list is empty); busy is high throughout.
// Results are registered, one per cycle, and cannot be stalled.
// Reset clears count, countdown and flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module repeating_delta_list_send_scheduler import rdls_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] msg_id_i,
  input  logic [15:0] start_delay_i,
  input  logic [15:0] repeat_period_i,
  input  logic [15:0] repeat_total_i,
  output logic        result_valid_o,
  output logic [15:0] sent_id_o,
  output logic        sent_valid_o,
  output logic        last_of_pass_o,
  output logic        all_done_o,
  output logic        overflow_o
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IW = $clog2(LIST_DEPTH);

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [15:0]    cd_q, cd_d;
  logic           run_q, run_d;
  logic           drop_q, drop_d;
  logic [RES_W-1:0] n_q, n_d, ri_q, ri_d;
  logic [CW-1:0]  pos_q, pos_d;
  logic [15:0]    nd_q, nd_d;

  logic [15:0] buf_id_q  [MAX_RESULTS];
  logic [15:0] buf_per_q [MAX_RESULTS];
  logic [15:0] buf_tot_q [MAX_RESULTS];

  logic        rv_q, rv_d, sv_q, sv_d, lp_q, lp_d, ad_q, ad_d, ov_q, ov_d;
  logic [15:0] sid_q, sid_d;

  cell_ctl_t     ctl;
  logic [CW-1:0] cpos;
  entry_t        cells [LIST_DEPTH];

  logic        acc, pop_go, walk_go, pos_in, full, qual, last;
  logic [15:0] rd_dly, b_id, b_per, b_tot;
  req_e        req;

  assign acc   = start && !busy;
  assign busy  = (state_q != ST_IDLE);
  assign req   = req_e'(req_type_i);
  assign full  = (cnt_q == CW'(LIST_DEPTH));
  assign pos_in = (pos_q < cnt_q);
  assign rd_dly = cells[pos_q[IW-1:0]].delay;
  assign pop_go = (cnt_q != '0) && (n_q < RES_W'(MAX_RESULTS)) && (cells[0].delay == '0);
  assign walk_go = pos_in && !(nd_q < rd_dly);
  assign b_id  = buf_id_q[ri_q[BUF_IW-1:0]];
  assign b_per = buf_per_q[ri_q[BUF_IW-1:0]];
  assign b_tot = buf_tot_q[ri_q[BUF_IW-1:0]];
  assign qual  = (b_per != '0) && ((b_tot == '0) || (b_tot > 16'd1));
  assign last  = ((ri_q + RES_W'(1)) == n_q);

  // cell row
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    entry_t lft, rgt;
    if (g == 0) begin : g_first
      assign lft = ctl.ent;
    end else begin : g_mid
      assign lft = cells[g-1];
    end
    if (g == LIST_DEPTH - 1) begin : g_last
      assign rgt = cells[g];
    end else begin : g_inner
      assign rgt = cells[g+1];
    end
    rdls_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .pos_i  (cpos),
      .left_i (lft),
      .right_i(rgt),
      .ent_o  (cells[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (req == REQ_START) state_d = ST_POP;
          else if (req == REQ_TICK && run_q && !(cd_q > 16'd1)) state_d = ST_POP;
        end
      end
      ST_POP:  if (!pop_go) state_d = ST_SEL;
      ST_SEL: begin
        if (ri_q == n_q) state_d = ST_FIN;
        else if (qual) state_d = ST_WALK;
      end
      ST_WALK: if (!walk_go) state_d = ST_INS;
      ST_INS:  state_d = ST_SEL;
      ST_FIN:  state_d = ST_EMIT;
      ST_EMIT: if (n_q == '0 || last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and cell control
  always_comb begin
    cnt_d = cnt_q; cd_d = cd_q; run_d = run_q; drop_d = drop_q;
    n_d = n_q; ri_d = ri_q; pos_d = pos_q; nd_d = nd_q;
    rv_d = 1'b0; sv_d = 1'b0; lp_d = 1'b0; ad_d = 1'b0; ov_d = drop_q; sid_d = '0;
    ctl.op = CELL_HOLD;
    ctl.ent = '0;
    cpos = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (req)
            REQ_APPEND: begin
              if (full) begin
                drop_d = 1'b1;
              end else begin
                ctl.op = CELL_INS;
                ctl.ent = '{id: msg_id_i, delay: start_delay_i,
                            period: repeat_period_i, total: repeat_total_i};
                cpos = cnt_q;
                cnt_d = cnt_q + CW'(1);
              end
            end
            REQ_START: n_d = '0;
            REQ_TICK: begin
              if (run_q) begin
                if (cd_q > 16'd1) cd_d = cd_q - 16'd1;
                else begin
                  cd_d = '0;
                  n_d = '0;
                end
              end
            end
            REQ_STOP: begin
              cnt_d = '0; cd_d = '0; run_d = 1'b0; drop_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        if (pop_go) begin
          ctl.op = CELL_SHL;
          cnt_d = cnt_q - CW'(1);
          n_d = n_q + RES_W'(1);
        end else begin
          ri_d = '0;
        end
      end
      ST_SEL: begin
        if (ri_q != n_q) begin
          if (qual) begin
            nd_d = b_per;
            pos_d = '0;
          end else begin
            ri_d = ri_q + RES_W'(1);
          end
        end
      end
      ST_WALK: begin
        if (walk_go) begin
          nd_d = nd_q - rd_dly;
          pos_d = pos_q + CW'(1);
        end else if (pos_in) begin
          ctl.op = CELL_SETD;
          ctl.ent.delay = rd_dly - nd_q;
        end
      end
      ST_INS: begin
        if (full) begin
          drop_d = 1'b1;
        end else begin
          ctl.op = CELL_INS;
          ctl.ent = '{id: b_id, delay: nd_q, period: b_per,
                      total: (b_tot != '0) ? (b_tot - 16'd1) : 16'd0};
          cnt_d = cnt_q + CW'(1);
        end
        ri_d = ri_q + RES_W'(1);
      end
      ST_FIN: begin
        if (cnt_q != '0) begin
          cd_d = cells[0].delay;
          ctl.op = CELL_SETD;
          ctl.ent.delay = '0;
          cpos = '0;
          run_d = 1'b1;
        end else begin
          cd_d = '0;
          run_d = 1'b0;
        end
        ri_d = '0;
      end
      ST_EMIT: begin
        if (n_q == '0) begin
          if (cnt_q == '0) begin
            rv_d = 1'b1; lp_d = 1'b1; ad_d = 1'b1;
          end
        end else begin
          rv_d = 1'b1;
          sv_d = 1'b1;
          sid_d = b_id;
          lp_d = last;
          ad_d = last && (cnt_q == '0);
          ri_d = ri_q + RES_W'(1);
        end
      end
      default: ;
    endcase
  end

  // popped entry buffer
  always_ff @(posedge clk_i) begin
    if (state_q == ST_POP && pop_go) begin
      buf_id_q[n_q[BUF_IW-1:0]]  <= cells[0].id;
      buf_per_q[n_q[BUF_IW-1:0]] <= cells[0].period;
      buf_tot_q[n_q[BUF_IW-1:0]] <= cells[0].total;
    end
  end

  always_ff @(posedge clk_i) begin
    sid_q <= sid_d;
    nd_q  <= nd_d;
    pos_q <= pos_d;
    ri_q  <= ri_d;
    n_q   <= n_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      cd_q    <= '0;
      run_q   <= 1'b0;
      drop_q  <= 1'b0;
      rv_q    <= 1'b0;
      sv_q    <= 1'b0;
      lp_q    <= 1'b0;
      ad_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cd_q    <= cd_d;
      run_q   <= run_d;
      drop_q  <= drop_d;
      rv_q    <= rv_d;
      sv_q    <= sv_d;
      lp_q    <= lp_d;
      ad_q    <= ad_d;
      ov_q    <= ov_d;
    end
  end

  assign result_valid_o = rv_q;
  assign sent_id_o      = sid_q;
  assign sent_valid_o   = sv_q;
  assign last_of_pass_o = lp_q;
  assign all_done_o     = ad_q;
  assign overflow_o     = ov_q;

endmodule

[test/tb_repeating_delta_list_send_scheduler.sv]
// ----------------------------------------------------------------------------
// tb_repeating_delta_list_send_scheduler
// Self-checking bench for the delta-list send scheduler: a short table of
// directed requests, then random bursts of appends, starts, ticks and stops.
// A behavioural copy of the list predicts every sent message; results are
// compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_repeating_delta_list_send_scheduler import rdls_pkg::*; ();

  localparam int unsigned DEPTH = 16;

  typedef struct packed {
    logic [15:0] id;
    logic        valid;
    logic        last;
    logic        done;
    logic        ovf;
  } sent_t;

  typedef struct {
    req_e        req;
    logic [15:0] id;
    logic [15:0] dly;
    logic [15:0] per;
    logic [15:0] tot;
    int          reps;
    bit          typed;
    sent_t       exp;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [15:0] msg_id_i = '0;
  logic [15:0] start_delay_i = '0;
  logic [15:0] repeat_period_i = '0;
  logic [15:0] repeat_total_i = '0;
  logic        result_valid_o;
  logic [15:0] sent_id_o;
  logic        sent_valid_o;
  logic        last_of_pass_o;
  logic        all_done_o;
  logic        overflow_o;

  repeating_delta_list_send_scheduler #(.LIST_DEPTH(DEPTH)) u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // scheduler copy
  entry_t      sched_list[DEPTH];
  int unsigned sched_count = 0;
  logic [15:0] sched_countdown = '0;
  bit          sched_running = 0;
  bit          sched_dropped = 0;
  sent_t       sends_due[$];
  int          errors = 0;

  function automatic void list_insert(int unsigned pos, entry_t e);
    if (sched_count >= DEPTH || pos > sched_count) begin
      sched_dropped = 1;
      return;
    end
    for (int k = sched_count; k > pos; k--) sched_list[k] = sched_list[k-1];
    sched_list[pos] = e;
    sched_count++;
  endfunction

  function automatic void run_send_pass(ref sent_t res[$]);
    entry_t      popped[$];
    entry_t      e;
    sent_t       s;
    int unsigned pos;
    logic [15:0] nd;
    while (popped.size() < sched_count && popped.size() < MAX_RESULTS &&
           sched_list[popped.size()].delay == 0)
      popped.insert(popped.size(), sched_list[popped.size()]);
    for (int k = 0; k + popped.size() < sched_count; k++)
      sched_list[k] = sched_list[k + popped.size()];
    sched_count -= popped.size();
    foreach (popped[i]) begin
      if (popped[i].period != 0 && popped[i].total != 1) begin
        nd = popped[i].period;
        pos = 0;
        while (pos < sched_count && !(nd < sched_list[pos].delay)) begin
          nd -= sched_list[pos].delay;
          pos++;
        end
        if (pos < sched_count) sched_list[pos].delay -= nd;
        e = popped[i];
        e.delay = nd;
        if (e.total != 0) e.total -= 1;
        list_insert(pos, e);
      end
    end
    if (sched_count > 0) begin
      sched_countdown = sched_list[0].delay;
      sched_list[0].delay = '0;
      sched_running = 1;
    end else begin
      sched_countdown = '0;
      sched_running = 0;
    end
    if (popped.size() == 0) begin
      if (sched_count == 0) begin
        s = '{16'h0, 1'b0, 1'b1, 1'b1, sched_dropped};
        res.insert(res.size(), s);
      end
      return;
    end
    foreach (popped[i]) begin
      s = '{popped[i].id, 1'b1, i == popped.size() - 1,
            (i == popped.size() - 1) && sched_count == 0, sched_dropped};
      res.insert(res.size(), s);
    end
  endfunction

  function automatic void predict_request(req_e req, entry_t e, ref sent_t res[$]);
    case (req)
      REQ_APPEND: list_insert(sched_count, e);
      REQ_START:  run_send_pass(res);
      REQ_TICK: begin
        if (sched_running) begin
          if (sched_countdown > 1) sched_countdown--;
          else begin
            sched_countdown = '0;
            run_send_pass(res);
          end
        end
      end
      default: begin
        sched_count = 0;
        sched_countdown = '0;
        sched_running = 0;
        sched_dropped = 0;
      end
    endcase
  endfunction

  // drive one item and wait for it to be taken
  task automatic issue(req_e req, entry_t e, bit typed, sent_t exp);
    sent_t res[$];
    req_type_i <= req;
    msg_id_i <= e.id;
    start_delay_i <= e.delay;
    repeat_period_i <= e.period;
    repeat_total_i <= e.total;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_request(req, e, res);
    if (typed) begin
      if (res.size() != 1 || res[0] !== exp) begin
        $display("%0t typed row disagrees: expected %p actual %p", $time, exp, res);
        errors++;
      end
      sends_due.insert(sends_due.size(), exp);
    end else begin
      foreach (res[i]) sends_due.insert(sends_due.size(), res[i]);
    end
  endtask

  int burst_left = 0;

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
    burst_left = $urandom_range(0, 8);
  endtask

  always @(posedge clk_i) begin
    sent_t got;
    sent_t want;
    if (rst_ni && result_valid_o) begin
      got = '{sent_id_o, sent_valid_o, last_of_pass_o, all_done_o, overflow_o};
      if (sends_due.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, got);
        errors++;
      end else begin
        want = sends_due.pop_front();
        if (got.id !== want.id)
          $display("%0t sent_id: expected %h actual %h", $time, want.id, got.id);
        if (got.valid !== want.valid)
          $display("%0t sent_valid: expected %b actual %b", $time, want.valid, got.valid);
        if (got.last !== want.last)
          $display("%0t last_of_pass: expected %b actual %b", $time, want.last, got.last);
        if (got.done !== want.done)
          $display("%0t all_done: expected %b actual %b", $time, want.done, got.done);
        if (got.ovf !== want.ovf)
          $display("%0t overflow: expected %b actual %b", $time, want.ovf, got.ovf);
        if (got !== want) errors++;
      end
    end
  end

  row_t directed[] = '{
    '{REQ_START,  16'h0,    16'h0,    16'h0,    16'h0,    1,  1, '{16'h0, 0, 1, 1, 0}},
    '{REQ_TICK,   16'h0,    16'h0,    16'h0,    16'h0,    1,  0, '0},
    '{REQ_APPEND, 16'hFFFF, 16'h0,    16'h0,    16'h1,    1,  0, '0},
    '{REQ_START,  16'h0,    16'h0,    16'h0,    16'h0,    1,  1, '{16'hFFFF, 1, 1, 1, 0}},
    '{REQ_APPEND, 16'h0001, 16'h0,    16'h3,    16'h0,    1,  0, '0},
    '{REQ_APPEND, 16'h0002, 16'h2,    16'hFFFF, 16'h2,    1,  0, '0},
    '{REQ_START,  16'h0,    16'h0,    16'h0,    16'h0,    1,  0, '0},
    '{REQ_TICK,   16'h0,    16'h0,    16'h0,    16'h0,    4,  0, '0},
    '{REQ_APPEND, 16'hA5A5, 16'h0,    16'h1,    16'h3,    16, 0, '0},
    '{REQ_START,  16'h0,    16'h0,    16'h0,    16'h0,    1,  0, '0},
    '{REQ_TICK,   16'h0,    16'h0,    16'h0,    16'h0,    4,  0, '0},
    '{REQ_STOP,   16'h0,    16'h0,    16'h0,    16'h0,    1,  0, '0},
    '{REQ_START,  16'h0,    16'h0,    16'h0,    16'h0,    1,  1, '{16'h0, 0, 1, 1, 0}},
    '{REQ_APPEND, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,  0, '0},
    '{REQ_START,  16'h0,    16'h0,    16'h0,    16'h0,    1,  0, '0},
    '{REQ_TICK,   16'h0,    16'h0,    16'h0,    16'h0,    2,  0, '0},
    '{REQ_STOP,   16'h0,    16'h0,    16'h0,    16'h0,    1,  0, '0}
  };

  initial begin
    entry_t e;
    int     pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[r])
      for (int k = 0; k < directed[r].reps; k++) begin
        e = '{directed[r].id, directed[r].dly, directed[r].per, directed[r].tot};
        issue(directed[r].req, e, directed[r].typed, directed[r].exp);
        pace();
      end
    for (int n = 0; n < 140; n++) begin
      pick = $urandom_range(0, 99);
      e.id = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        e.delay = 16'($urandom);
        e.period = 16'($urandom);
        e.total = 16'($urandom);
      end else begin
        e.delay = 16'($urandom_range(0, 3));
        e.period = 16'($urandom_range(0, 4));
        e.total = 16'($urandom_range(0, 4));
      end
      if (pick < 40) issue(REQ_APPEND, e, 0, '0);
      else if (pick < 48) issue(REQ_START, e, 0, '0);
      else if (pick < 97) issue(REQ_TICK, e, 0, '0);
      else issue(REQ_STOP, e, 0, '0);
      pace();
    end
    start <= 1'b0;
    while (sends_due.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && sends_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("FAIL");
    $finish;
  end

endmodule
